[rtl/core/sorted_priority_queue_kind_counts_macros.svh]
// assertion macros for the sorted priority queue block
// expects i_clk and i_rst_n in the scope of the module that uses them
`ifndef SORTED_PRIORITY_QUEUE_KIND_COUNTS_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_KIND_COUNTS_MACROS_SVH
`ifndef SYNTHESIS
`define SPQKC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("spqkc assertion failed");
`define SPQKC_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("spqkc reset assertion failed");
`else
`define SPQKC_ASSERT(lbl, prop)
`define SPQKC_ASSERT_RST(lbl, prop)
`endif
`endif

[rtl/core/spqkc_pkg.sv]
// shared types and constants of the sorted priority queue block
// no dependencies
package spqkc_pkg;

    localparam int CAPACITY  = 64;
    localparam int FILL_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W   = 32;
    localparam int CODE_W    = 63;
    localparam int KIND_W    = 2;
    localparam int OUT_CNT_W = 7;

    localparam logic [KIND_W-1:0] KIND_B = 2'd0;
    localparam logic [KIND_W-1:0] KIND_G = 2'd1;
    localparam logic [KIND_W-1:0] KIND_P = 2'd2;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [CODE_W-1:0]  code;
        logic [KIND_W-1:0]  kind;
    } t_entry;

    typedef struct packed {
        logic   ins;
        logic   rem;
        t_entry item;
    } t_cell_ctl;

    typedef struct packed {
        logic               req_type;
        t_entry             item;
    } t_req_item;

    typedef struct packed {
        logic                 removed_valid;
        t_entry               item;
        t_status              status;
        logic [OUT_CNT_W-1:0] count_b;
        logic [OUT_CNT_W-1:0] count_g;
        logic [OUT_CNT_W-1:0] count_p;
        logic [OUT_CNT_W-1:0] occupancy;
    } t_rsp_item;

endpackage

[rtl/core/spqkc_req_if.sv]
// request channel: insert or remove transaction
// depends on spqkc_pkg
interface spqkc_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [spqkc_pkg::VALUE_W-1:0] entry_value;
    logic [spqkc_pkg::CODE_W-1:0]  entry_code;
    logic [spqkc_pkg::KIND_W-1:0]  entry_kind;

    modport source (output valid, req_type, entry_value, entry_code, entry_kind,
                    input ready);
    modport sink (input valid, req_type, entry_value, entry_code, entry_kind,
                  output ready);
endinterface

[rtl/core/spqkc_rsp_if.sv]
// result channel: removed entry, status and counts
// depends on spqkc_pkg
interface spqkc_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            removed_valid;
    logic [spqkc_pkg::VALUE_W-1:0]   removed_value;
    logic [spqkc_pkg::CODE_W-1:0]    removed_code;
    logic [spqkc_pkg::KIND_W-1:0]    removed_kind;
    logic [1:0]                      status_code;
    logic [spqkc_pkg::OUT_CNT_W-1:0] count_b;
    logic [spqkc_pkg::OUT_CNT_W-1:0] count_g;
    logic [spqkc_pkg::OUT_CNT_W-1:0] count_p;
    logic [spqkc_pkg::OUT_CNT_W-1:0] occupancy;

    modport source (output valid, removed_valid, removed_value, removed_code,
                    removed_kind, status_code, count_b, count_g, count_p, occupancy,
                    input ready);
    modport sink (input valid, removed_valid, removed_value, removed_code,
                  removed_kind, status_code, count_b, count_g, count_p, occupancy,
                  output ready);
endinterface

[rtl/core/spqkc_cell.sv]
// one slot of the sorted chain, largest entry toward cell zero
// depends on spqkc_pkg
module spqkc_cell (
    input  logic                 i_clk,
    input  spqkc_pkg::t_cell_ctl i_ctl,
    input  logic                 i_valid,
    input  spqkc_pkg::t_entry    i_upper,
    input  logic                 i_upper_keep,
    input  spqkc_pkg::t_entry    i_lower,
    output spqkc_pkg::t_entry    o_entry,
    output logic                 o_keep
);
    spqkc_pkg::t_entry r_entry;
    spqkc_pkg::t_entry n_entry;

    // strictly greater stays above the new entry, equals move down
    assign o_keep  = i_valid && (r_entry.value > i_ctl.item.value);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        priority if (i_ctl.ins) begin
            if (o_keep) begin
                n_entry = r_entry;
            end else if (i_upper_keep) begin
                n_entry = i_ctl.item;
            end else begin
                n_entry = i_upper;
            end
        end else if (i_ctl.rem) begin
            n_entry = i_lower;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end
endmodule

[rtl/core/sorted_priority_queue_kind_counts.sv]
// Sorted priority queue with running counts of kinds b, g and p.
// Request channel i_req (valid/ready): req_type 0 inserts entry_value,
// entry_code and entry_kind, req_type 1 removes the largest entry.
// Result channel o_rsp (valid/ready): one transaction per request with the
// removed entry (if any), status_code and the counts after the request.
// Entries live in a chain of CAPACITY cells kept in descending order; an
// insert compares the new value in every cell at once and the lower part of
// the chain shifts down by one, a remove shifts the whole chain up by one.
// A request is registered on acceptance and applied to the chain once the
// result register is free or is being read, in the same cycle that loads
// the result register. Throughput: one request per cycle while
// the result side takes each result; the request register and the result
// register each hold one transaction, so a new request is taken while a
// result waits, and a stalled receiver stops intake once both are full.
// Reset (synchronous, active low) empties the queue and zeroes the counts;
// cell contents are not cleared, only entries below the fill count are read.
// Insert when full returns status 1, remove when empty status 2, and
// neither changes the queue.
`include "sorted_priority_queue_kind_counts_macros.svh"
module sorted_priority_queue_kind_counts (
    input logic        i_clk,
    input logic        i_rst_n,
    spqkc_req_if.sink   i_req,
    spqkc_rsp_if.source o_rsp
);
    localparam int CAP = spqkc_pkg::CAPACITY;
    localparam int FW  = spqkc_pkg::FILL_W;
    localparam int OW  = spqkc_pkg::OUT_CNT_W;

    logic                  r_req_vld;
    spqkc_pkg::t_req_item  r_req;
    logic                  r_rsp_vld;
    spqkc_pkg::t_rsp_item  r_rsp;
    logic [FW-1:0]         r_fill;
    logic [FW-1:0]         r_cnt_b;
    logic [FW-1:0]         r_cnt_g;
    logic [FW-1:0]         r_cnt_p;

    logic [FW-1:0]         n_fill;
    logic [FW-1:0]         n_cnt_b;
    logic [FW-1:0]         n_cnt_g;
    logic [FW-1:0]         n_cnt_p;
    spqkc_pkg::t_rsp_item  n_rsp;

    logic                  w_fire;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_do_ins;
    logic                  w_do_rem;
    logic [spqkc_pkg::KIND_W-1:0] w_kind;
    spqkc_pkg::t_cell_ctl  w_ctl;
    spqkc_pkg::t_entry     w_entry [CAP];
    logic                  w_keep  [CAP];

    assign w_fire   = r_req_vld && (!r_rsp_vld || o_rsp.ready);
    assign w_full   = (r_fill == FW'(CAP));
    assign w_empty  = (r_fill == '0);
    assign w_do_ins = w_fire && (r_req.req_type == spqkc_pkg::REQ_INSERT) && !w_full;
    assign w_do_rem = w_fire && (r_req.req_type == spqkc_pkg::REQ_REMOVE) && !w_empty;
    assign w_kind   = w_do_ins ? r_req.item.kind : w_entry[0].kind;

    assign i_req.ready = !r_req_vld || w_fire;

    assign w_ctl.ins  = w_do_ins;
    assign w_ctl.rem  = w_do_rem;
    assign w_ctl.item = r_req.item;

    for (genvar gi = 0; gi < CAP; gi++) begin : g_cell
        spqkc_pkg::t_entry w_upper;
        spqkc_pkg::t_entry w_lower;
        logic              w_upper_keep;
        if (gi == 0) begin : g_head
            assign w_upper      = w_entry[gi];
            assign w_upper_keep = 1'b1;
        end else begin : g_mid
            assign w_upper      = w_entry[gi-1];
            assign w_upper_keep = w_keep[gi-1];
        end
        if (gi == CAP - 1) begin : g_tail
            assign w_lower = w_entry[gi];
        end else begin : g_body
            assign w_lower = w_entry[gi+1];
        end
        spqkc_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_valid      (FW'(gi) < r_fill),
            .i_upper      (w_upper),
            .i_upper_keep (w_upper_keep),
            .i_lower      (w_lower),
            .o_entry      (w_entry[gi]),
            .o_keep       (w_keep[gi])
        );
    end

    // fill and kind counts
    always_comb begin
        n_fill  = r_fill;
        n_cnt_b = r_cnt_b;
        n_cnt_g = r_cnt_g;
        n_cnt_p = r_cnt_p;
        if (w_do_ins) begin
            n_fill = r_fill + 1'b1;
            if (w_kind == spqkc_pkg::KIND_B) n_cnt_b = r_cnt_b + 1'b1;
            if (w_kind == spqkc_pkg::KIND_G) n_cnt_g = r_cnt_g + 1'b1;
            if (w_kind == spqkc_pkg::KIND_P) n_cnt_p = r_cnt_p + 1'b1;
        end else if (w_do_rem) begin
            n_fill = r_fill - 1'b1;
            if (w_kind == spqkc_pkg::KIND_B && r_cnt_b != '0) n_cnt_b = r_cnt_b - 1'b1;
            if (w_kind == spqkc_pkg::KIND_G && r_cnt_g != '0) n_cnt_g = r_cnt_g - 1'b1;
            if (w_kind == spqkc_pkg::KIND_P && r_cnt_p != '0) n_cnt_p = r_cnt_p - 1'b1;
        end
    end

    // result transaction
    always_comb begin
        n_rsp               = '0;
        n_rsp.removed_valid = w_do_rem;
        if (w_do_rem) begin
            n_rsp.item = w_entry[0];
        end
        priority if (r_req.req_type == spqkc_pkg::REQ_INSERT && w_full) begin
            n_rsp.status = spqkc_pkg::ST_FULL;
        end else if (r_req.req_type == spqkc_pkg::REQ_REMOVE && w_empty) begin
            n_rsp.status = spqkc_pkg::ST_EMPTY;
        end else begin
            n_rsp.status = spqkc_pkg::ST_OK;
        end
        n_rsp.count_b   = OW'(n_cnt_b);
        n_rsp.count_g   = OW'(n_cnt_g);
        n_rsp.count_p   = OW'(n_cnt_p);
        n_rsp.occupancy = OW'(n_fill);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_rsp_vld <= 1'b0;
            r_fill    <= '0;
            r_cnt_b   <= '0;
            r_cnt_g   <= '0;
            r_cnt_p   <= '0;
        end else begin
            if (i_req.ready) begin
                r_req_vld <= i_req.valid;
            end
            if (w_fire) begin
                r_rsp_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_vld <= 1'b0;
            end
            r_fill  <= n_fill;
            r_cnt_b <= n_cnt_b;
            r_cnt_g <= n_cnt_g;
            r_cnt_p <= n_cnt_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req.req_type   <= i_req.req_type;
            r_req.item.value <= i_req.entry_value;
            r_req.item.code  <= i_req.entry_code;
            r_req.item.kind  <= i_req.entry_kind;
        end
        if (w_fire) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid         = r_rsp_vld;
    assign o_rsp.removed_valid = r_rsp.removed_valid;
    assign o_rsp.removed_value = r_rsp.item.value;
    assign o_rsp.removed_code  = r_rsp.item.code;
    assign o_rsp.removed_kind  = r_rsp.item.kind;
    assign o_rsp.status_code   = r_rsp.status;
    assign o_rsp.count_b       = r_rsp.count_b;
    assign o_rsp.count_g       = r_rsp.count_g;
    assign o_rsp.count_p       = r_rsp.count_p;
    assign o_rsp.occupancy     = r_rsp.occupancy;

    `SPQKC_ASSERT(a_fill_bound, r_fill <= FW'(CAP))
    `SPQKC_ASSERT(a_counts_bound,
        (({2'b00, r_cnt_b} + {2'b00, r_cnt_g} + {2'b00, r_cnt_p}) <= {2'b00, r_fill}))
    `SPQKC_ASSERT(a_insert_grows, w_do_ins |=> r_fill == FW'($past(r_fill) + 1'b1))
    `SPQKC_ASSERT(a_remove_result, w_do_rem |=> r_rsp_vld && r_rsp.removed_valid)
    `SPQKC_ASSERT_RST(a_reset_empty, !i_rst_n |=> r_fill == '0 && !r_rsp_vld && !r_req_vld)
endmodule
